// File: rtl/core/bcag_pkg.sv
// bcag_pkg: shared types, codes and field layout for the broadcast operand
// address generator. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bcag_pkg;

	// parameter defaults
	localparam int MAX_AXES_DEF   = 8;
	localparam int DIM_BITS_DEF   = 16;
	localparam int INDEX_BITS_DEF = 32;

	// fixed field widths
	localparam int AXIS_W      = 3;
	localparam int DIM_FIELD_W = 16;
	localparam int STRIDE_W    = 32;
	localparam int LIN_IDX_W   = 32;
	localparam int OFF_W       = 32;
	localparam int RANK_W      = 4;
	localparam int COUNT_W     = 32;

	// slave tdata layout
	localparam int AXIS_LSB     = 0;
	localparam int OUT_DIM_LSB  = AXIS_LSB + AXIS_W;
	localparam int A_DIM_LSB    = OUT_DIM_LSB + DIM_FIELD_W;
	localparam int A_STRIDE_LSB = A_DIM_LSB + DIM_FIELD_W;
	localparam int B_DIM_LSB    = A_STRIDE_LSB + STRIDE_W;
	localparam int B_STRIDE_LSB = B_DIM_LSB + DIM_FIELD_W;
	localparam int LIN_IDX_LSB  = B_STRIDE_LSB + STRIDE_W;
	localparam int S_FIELDS_W   = LIN_IDX_LSB + LIN_IDX_W;
	localparam int S_TDATA_W    = ((S_FIELDS_W + 7) / 8) * 8;

	// master tdata layout
	localparam int M_TDATA_W = 3 * OFF_W;

	// configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_OUT_RANK      = 2'd0,
		CFG_A_RANK        = 2'd1,
		CFG_B_RANK        = 2'd2,
		CFG_ELEMENT_COUNT = 2'd3
	} cfg_reg_t;

	typedef enum logic {
		ACT_LOAD    = 1'b0,
		ACT_COMPUTE = 1'b1
	} action_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_LOAD,
		ST_DIV,
		ST_MUL,
		ST_ACC,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic tab_wr;
		logic start;
		logic div_load;
		logic div_step;
		logic mul;
		logic acc;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic in_range;
		logic rank_zero;
		logic last_round;
		logic out_free;
	} sts_t;

endpackage

`default_nettype wire

// File: rtl/core/bcag_div.sv
// bcag_div: restoring divider, one quotient bit per step.
// Divisor zero gives quotient zero and remainder equal to the dividend.
`timescale 1ns / 1ps
`default_nettype none

module bcag_div #(
	parameter int NUM_W = 32,
	parameter int DEN_W = 16
) (
	input  wire logic             clk,
	input  wire logic             load,
	input  wire logic             step,
	input  wire logic [NUM_W-1:0] num,
	input  wire logic [DEN_W-1:0] den,
	output logic      [NUM_W-1:0] quo,
	output logic      [NUM_W-1:0] rem
);

	localparam int CW = ((NUM_W > DEN_W) ? NUM_W : DEN_W) + 1;

	logic [NUM_W-1:0] quo_q;
	logic [NUM_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [NUM_W:0]   trial;
	logic [CW-1:0]    trial_x;
	logic [CW-1:0]    den_x;
	logic [CW-1:0]    diff;
	logic             fits;

	assign trial   = {rem_q, quo_q[NUM_W-1]};
	assign trial_x = CW'(trial);
	assign den_x   = CW'(den_q);
	assign fits    = trial_x >= den_x;
	assign diff    = trial_x - den_x;

	always_ff @(posedge clk) begin
		if (load) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (step) begin
			rem_q <= fits ? diff[NUM_W-1:0] : trial[NUM_W-1:0];
			quo_q <= {quo_q[NUM_W-2:0], fits};
		end
	end

	assign quo = (den_q == '0) ? '0 : quo_q;
	assign rem = rem_q;

endmodule

`default_nettype wire

// File: rtl/core/bcag_ctrl.sv
// bcag_ctrl: sequencer for load and compute transactions.
// Depends on bcag_pkg; drives the datapath through cmd_t, reads sts_t.
`timescale 1ns / 1ps
`default_nettype none

module bcag_ctrl import bcag_pkg::*; #(
	parameter int INDEX_BITS = INDEX_BITS_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic s_tvalid,
	input  wire logic s_tuser,
	output logic      s_tready,
	input  wire sts_t sts,
	output cmd_t      cmd
);

	localparam int SW = $clog2(INDEX_BITS);

	state_t        state_q;
	state_t        state_d;
	logic [SW-1:0] cnt_q;
	logic          cnt_last;

	assign cnt_last = cnt_q == SW'(INDEX_BITS - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (cmd.div_load)
				cnt_q <= '0;
			else if (cmd.div_step)
				cnt_q <= cnt_q + 1'b1;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					if (action_t'(s_tuser) == ACT_COMPUTE) begin
						cmd.start = 1'b1;
						state_d   = ST_CHECK;
					end else begin
						cmd.tab_wr = 1'b1;
					end
				end
			end
			ST_CHECK: begin
				if (!sts.in_range || sts.rank_zero)
					state_d = ST_OUT;
				else
					state_d = ST_LOAD;
			end
			ST_LOAD: begin
				cmd.div_load = 1'b1;
				state_d      = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (cnt_last)
					state_d = ST_MUL;
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_ACC;
			end
			ST_ACC: begin
				cmd.acc = 1'b1;
				state_d = sts.last_round ? ST_OUT : ST_LOAD;
			end
			ST_OUT: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

`default_nettype wire

// File: rtl/core/bcag_dp.sv
// bcag_dp: config registers, axis tables, three dividers, two multipliers,
// offset accumulators and the output register. Depends on bcag_pkg, bcag_div.
`timescale 1ns / 1ps
`default_nettype none

module bcag_dp import bcag_pkg::*; #(
	parameter int MAX_AXES   = MAX_AXES_DEF,
	parameter int DIM_BITS   = DIM_BITS_DEF,
	parameter int INDEX_BITS = INDEX_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic [S_TDATA_W-1:0]  s_tdata,
	input  wire cmd_t                  cmd,
	output sts_t                       sts,
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic [M_TDATA_W-1:0]       m_tdata,
	output logic                       m_tuser
);

	localparam int AXW  = (MAX_AXES > 1) ? $clog2(MAX_AXES) : 1;
	localparam int RW   = ($clog2(MAX_AXES + 1) > 4) ? $clog2(MAX_AXES + 1) + 1 : 5;
	localparam int CMPW = (INDEX_BITS > COUNT_W) ? INDEX_BITS : COUNT_W;

	// configuration
	logic [RANK_W-1:0]  out_rank_q;
	logic [RANK_W-1:0]  a_rank_q;
	logic [RANK_W-1:0]  b_rank_q;
	logic [COUNT_W-1:0] element_count_q;

	// axis tables, contents undefined until loaded
	logic [DIM_BITS-1:0] out_dim_tab_q  [MAX_AXES];
	logic [DIM_BITS-1:0] a_dim_tab_q    [MAX_AXES];
	logic [STRIDE_W-1:0] a_stride_tab_q [MAX_AXES];
	logic [DIM_BITS-1:0] b_dim_tab_q    [MAX_AXES];
	logic [STRIDE_W-1:0] b_stride_tab_q [MAX_AXES];

	logic [AXIS_W-1:0]     axis_in;
	logic [INDEX_BITS-1:0] idx_in;

	logic [INDEX_BITS-1:0] idx_q;
	logic [INDEX_BITS-1:0] rest_q;
	logic [INDEX_BITS-1:0] coord_q;
	logic [RW-1:0]         rnd_q;
	logic                  in_range_q;
	logic [OFF_W-1:0]      prod_a_q;
	logic [OFF_W-1:0]      prod_b_q;
	logic [OFF_W-1:0]      acc_a_q;
	logic [OFF_W-1:0]      acc_b_q;
	logic                  m_tvalid_q;
	logic [M_TDATA_W-1:0]  m_tdata_q;
	logic                  m_tuser_q;

	logic [RW-1:0]  rank;
	logic [RW-1:0]  ra;
	logic [RW-1:0]  rb;
	logic [RW-1:0]  main_ax;
	logic [RW-1:0]  mod_ax;
	logic [AXW-1:0] main_sel;
	logic [AXW-1:0] mod_sel;
	logic           mod_on;
	logic           a_en;
	logic           b_en;

	logic [INDEX_BITS-1:0] main_quo;
	logic [INDEX_BITS-1:0] main_rem;
	logic [INDEX_BITS-1:0] a_rem;
	logic [INDEX_BITS-1:0] b_rem;

	assign axis_in = s_tdata[AXIS_LSB +: AXIS_W];
	assign idx_in  = INDEX_BITS'(s_tdata[LIN_IDX_LSB +: LIN_IDX_W]);

	always_comb begin
		rank = (RW'(out_rank_q) > RW'(MAX_AXES)) ? RW'(MAX_AXES) : RW'(out_rank_q);
		ra   = (RW'(a_rank_q) > rank) ? rank : RW'(a_rank_q);
		rb   = (RW'(b_rank_q) > rank) ? rank : RW'(b_rank_q);
	end

	// round r divides on axis rank-1-r and folds the coordinate of axis rank-r
	assign main_ax  = rank - rnd_q - 1'b1;
	assign mod_ax   = rank - rnd_q;
	assign main_sel = main_ax[AXW-1:0];
	assign mod_sel  = mod_ax[AXW-1:0];
	assign mod_on   = rnd_q != '0;
	assign a_en     = mod_on && (mod_ax >= rank - ra);
	assign b_en     = mod_on && (mod_ax >= rank - rb);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_rank_q      <= RANK_W'(1);
			a_rank_q        <= RANK_W'(1);
			b_rank_q        <= RANK_W'(1);
			element_count_q <= '0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				CFG_OUT_RANK:      out_rank_q      <= cfg_data[RANK_W-1:0];
				CFG_A_RANK:        a_rank_q        <= cfg_data[RANK_W-1:0];
				CFG_B_RANK:        b_rank_q        <= cfg_data[RANK_W-1:0];
				CFG_ELEMENT_COUNT: element_count_q <= cfg_data[COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.tab_wr && (int'(axis_in) < MAX_AXES)) begin
			out_dim_tab_q[AXW'(axis_in)]  <= DIM_BITS'(s_tdata[OUT_DIM_LSB +: DIM_FIELD_W]);
			a_dim_tab_q[AXW'(axis_in)]    <= DIM_BITS'(s_tdata[A_DIM_LSB +: DIM_FIELD_W]);
			a_stride_tab_q[AXW'(axis_in)] <= s_tdata[A_STRIDE_LSB +: STRIDE_W];
			b_dim_tab_q[AXW'(axis_in)]    <= DIM_BITS'(s_tdata[B_DIM_LSB +: DIM_FIELD_W]);
			b_stride_tab_q[AXW'(axis_in)] <= s_tdata[B_STRIDE_LSB +: STRIDE_W];
		end
	end

	bcag_div #(.NUM_W(INDEX_BITS), .DEN_W(DIM_BITS)) u_div_main (
		.clk  (clk),
		.load (cmd.div_load),
		.step (cmd.div_step),
		.num  (rest_q),
		.den  (out_dim_tab_q[main_sel]),
		.quo  (main_quo),
		.rem  (main_rem)
	);

	bcag_div #(.NUM_W(INDEX_BITS), .DEN_W(DIM_BITS)) u_div_a (
		.clk  (clk),
		.load (cmd.div_load),
		.step (cmd.div_step),
		.num  (coord_q),
		.den  (a_dim_tab_q[mod_sel]),
		.quo  (),
		.rem  (a_rem)
	);

	bcag_div #(.NUM_W(INDEX_BITS), .DEN_W(DIM_BITS)) u_div_b (
		.clk  (clk),
		.load (cmd.div_load),
		.step (cmd.div_step),
		.num  (coord_q),
		.den  (b_dim_tab_q[mod_sel]),
		.quo  (),
		.rem  (b_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rnd_q      <= '0;
			in_range_q <= 1'b0;
		end else if (cmd.start) begin
			rnd_q      <= '0;
			in_range_q <= CMPW'(idx_in) < CMPW'(element_count_q);
		end else if (cmd.acc) begin
			rnd_q <= rnd_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			idx_q   <= idx_in;
			rest_q  <= idx_in;
			acc_a_q <= '0;
			acc_b_q <= '0;
		end
		if (cmd.mul) begin
			prod_a_q <= a_en ? OFF_W'(a_rem) * a_stride_tab_q[mod_sel] : '0;
			prod_b_q <= b_en ? OFF_W'(b_rem) * b_stride_tab_q[mod_sel] : '0;
		end
		if (cmd.acc) begin
			acc_a_q <= acc_a_q + prod_a_q;
			acc_b_q <= acc_b_q + prod_b_q;
			coord_q <= main_rem;
			rest_q  <= main_quo;
		end
		if (cmd.out_load) begin
			m_tdata_q <= {OFF_W'(idx_q), acc_b_q, acc_a_q};
			m_tuser_q <= in_range_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_tvalid_q <= 1'b0;
		else if (cmd.out_load)
			m_tvalid_q <= 1'b1;
		else if (m_tready)
			m_tvalid_q <= 1'b0;
	end

	assign sts.in_range   = in_range_q;
	assign sts.rank_zero  = rank == '0;
	assign sts.last_round = rnd_q == rank;
	assign sts.out_free   = !m_tvalid_q || m_tready;

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	a_rnd_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.acc |-> rnd_q <= rank)
		else $error("round count beyond rank");

	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!m_tvalid_q || m_tready))
		else $error("output register overwritten");

	a_oor_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.out_load && !in_range_q) |=> (m_tdata[2*OFF_W-1:0] == '0 && !m_tuser))
		else $error("out of range result carries offsets");

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start |-> !(cmd.acc || cmd.mul || cmd.out_load || cmd.tab_wr))
		else $error("compute start overlaps other work");

endmodule

`default_nettype wire

// File: rtl/core/broadcast_operand_address_generator_core.sv
// broadcast_operand_address_generator_core: top level, joins bcag_ctrl and
// bcag_dp. Depends on bcag_pkg, bcag_ctrl, bcag_dp, bcag_div.
//
// channel  direction  signals                       payload
// s_       in         s_tvalid/s_tready             s_tdata, s_tuser (action)
// m_       out        m_tvalid/m_tready             m_tdata, m_tuser (in_range)
// cfg_     in         cfg_we                        cfg_index, cfg_data
//
// A load transaction gives no result.
// A compute transaction passes CHECK, then rank + 1 axis rounds of LOAD, bit-serial
// divide (DIV), MUL and ACC (rank = effective out_rank), then OUT before m_tvalid;
// out-of-range or rank-zero transactions go from CHECK straight to OUT.
// Reset clears config registers and control; axis tables stay undefined until loaded.
// A held result in the output register does not stop the next transaction being taken.
`timescale 1ns / 1ps
`default_nettype none

module broadcast_operand_address_generator_core import bcag_pkg::*; #(
	parameter int MAX_AXES   = MAX_AXES_DEF,
	parameter int DIM_BITS   = DIM_BITS_DEF,
	parameter int INDEX_BITS = INDEX_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	// axis, out_dim, a_dim, a_stride, b_dim, b_stride, linear_index, zero pad
	input  wire logic [S_TDATA_W-1:0]  s_tdata,
	// action
	input  wire logic                  s_tuser,
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	// a_offset, b_offset, out_index
	output logic [M_TDATA_W-1:0]       m_tdata,
	// in_range
	output logic                       m_tuser
);

	cmd_t cmd;
	sts_t sts;

	bcag_ctrl #(.INDEX_BITS(INDEX_BITS)) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tuser  (s_tuser),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	bcag_dp #(
		.MAX_AXES   (MAX_AXES),
		.DIM_BITS   (DIM_BITS),
		.INDEX_BITS (INDEX_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tdata   (s_tdata),
		.cmd       (cmd),
		.sts       (sts),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

endmodule

`default_nettype wire
